### rtl/bec_pkg.sv
// Package for the bipartite edge colourer: constants, command codes and the
// sequencer state type. No dependencies.
package bec_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_COLORS_DEF   = 16;
    localparam int MAX_EDGES_DEF    = 255;
    localparam int MAX_HOPS         = 31;

    localparam int EDGE_W   = 8;
    localparam int VERT_W   = 6;
    localparam int COLOR_W  = 5;
    localparam int DEG_W    = 5;
    localparam int CNT_W    = 6;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_FREE,
        ST_WAIT_FREE,
        ST_DECIDE,
        ST_OWN_U,
        ST_OWN_V,
        ST_FREE_U,
        ST_FREE_V,
        ST_RD_OWNER,
        ST_WAIT_OWNER,
        ST_CHECK,
        ST_RD_ENDS,
        ST_WAIT_ENDS,
        ST_OWN_F0,
        ST_OWN_F1,
        ST_STEP,
        ST_FIN_U,
        ST_FIN_V,
        ST_FIN_W,
        ST_FIN_OWN,
        ST_FIN_WSET,
        ST_EMIT
    } bec_state_t;

endpackage

### rtl/bec_mem.sv
// Generic single-port synchronous memory with registered read.
// Depends on nothing.
module bec_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write-first is not needed; reads and writes are sequenced
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end
endmodule

### rtl/bipartite_edge_coloring.sv
// Bipartite edge colourer, top level: sequencer around three memories.
// Depends on bec_pkg and bec_mem.
//
// One transaction at a time. A bad operand or a missing free colour gives an
// error result. A direct colouring steps through the accepting cycle, two
// free-map reads, the decision, two owner writes, two free-map
// read-modify-writes and the result. An alternating path takes one hop for
// every edge met before the last one. Each such hop is an owner read, an
// edge-end read and two owner writes, each through the single port of the
// owner memory. The path ending is three free-map read-modify-writes and
// three owner writes. After reset and after every clear command a clearing
// pass sweeps the free-colour and owner memories, during which no input is
// taken. A result waits in an output register, and the sequencer stalls only
// on that register.
module bipartite_edge_coloring #(
    parameter int MAX_VERTICES = bec_pkg::MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = bec_pkg::MAX_COLORS_DEF,
    parameter int MAX_EDGES    = bec_pkg::MAX_EDGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // edge_id[7:0], left_vertex[13:8], right_vertex[19:14]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // colored_edge[7:0], color[12:8], error[13]
    output logic        m_tlast
);
    import bec_pkg::*;

    localparam int VA = $clog2(MAX_VERTICES + 1);
    localparam int ODEPTH = (MAX_VERTICES + 1) * (MAX_COLORS + 1);
    localparam int OA = $clog2(ODEPTH);
    localparam int EA = $clog2(MAX_EDGES + 1);

    // configuration
    logic [DEG_W-1:0] max_degree_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_degree_reg <= DEG_W'(16);
        else if (cfg_valid)
            max_degree_reg <= cfg_data;
    end

    logic [MAX_COLORS-1:0] mask;
    always_comb
    begin
        mask = '0;
        for (int i = 0; i < MAX_COLORS; i++)
            if (i < int'(max_degree_reg)) mask[i] = 1'b1;
    end

    // memories
    logic              fr_we;
    logic [VA-1:0]     fr_addr;
    logic [MAX_COLORS-1:0] fr_wdata, fr_rdata;
    logic              ow_we;
    logic [OA-1:0]     ow_addr;
    logic [EDGE_W-1:0] ow_wdata, ow_rdata;
    logic              ee_we;
    logic [EA-1:0]     ee_addr;
    logic [2*VERT_W-1:0] ee_wdata, ee_rdata;

    bec_mem #(.WIDTH(MAX_COLORS), .DEPTH(MAX_VERTICES + 1)) u_free (
        .clk(clk), .we(fr_we), .addr(fr_addr), .wdata(fr_wdata), .rdata(fr_rdata));
    bec_mem #(.WIDTH(EDGE_W), .DEPTH(ODEPTH)) u_owner (
        .clk(clk), .we(ow_we), .addr(ow_addr), .wdata(ow_wdata), .rdata(ow_rdata));
    bec_mem #(.WIDTH(2*VERT_W), .DEPTH(MAX_EDGES + 1)) u_ends (
        .clk(clk), .we(ee_we), .addr(ee_addr), .wdata(ee_wdata), .rdata(ee_rdata));

    function automatic logic [OA-1:0] oidx(input logic [VERT_W-1:0] v,
                                           input logic [COLOR_W-1:0] c);
        logic [OA-1:0] r;
        r = OA'(v) * OA'(MAX_COLORS + 1) + OA'(c);
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] lowest(input logic [MAX_COLORS-1:0] b);
        logic [COLOR_W-1:0] r;
        r = '0;
        for (int i = MAX_COLORS - 1; i >= 0; i--)
            if (b[i]) r = COLOR_W'(i + 1);
        return r;
    endfunction

    // sequencer registers
    bec_state_t state_reg, state_next;
    logic [OA-1:0]        clr_reg, clr_next;
    logic [EDGE_W-1:0]    e_reg, e_next, f_reg, f_next, nx_reg, nx_next;
    logic [VERT_W-1:0]    u_reg, u_next, v_reg, v_next, w_reg, w_next;
    logic [VERT_W-1:0]    f0_reg, f0_next, f1_reg, f1_next;
    logic [MAX_COLORS-1:0] fu_reg, fu_next;
    logic [COLOR_W-1:0]   ca_reg, ca_next, cb_reg, cb_next, c_reg, c_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic                 fin_reg, fin_next;   // direct colouring
    logic                 ov_reg, ov_next;
    logic [15:0]          od_reg, od_next;
    logic                 ol_reg, ol_next;

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;  f_reg <= f_next;  nx_reg <= nx_next;
        u_reg <= u_next;  v_reg <= v_next;  w_reg <= w_next;
        f0_reg <= f0_next; f1_reg <= f1_next; fu_reg <= fu_next;
        ca_reg <= ca_next; cb_reg <= cb_next; c_reg <= c_next;
        k_reg <= k_next;  fin_reg <= fin_next;
        od_reg <= od_next; ol_reg <= ol_next;
    end

    // next state and memory controls
    always_comb
    begin
        logic [MAX_COLORS-1:0] fv, both;
        logic [COLOR_W-1:0] other;
        logic out_free;
        state_next = state_reg; clr_next = clr_reg;
        e_next = e_reg; f_next = f_reg; nx_next = nx_reg;
        u_next = u_reg; v_next = v_reg; w_next = w_reg;
        f0_next = f0_reg; f1_next = f1_reg; fu_next = fu_reg;
        ca_next = ca_reg; cb_next = cb_reg; c_next = c_reg;
        k_next = k_reg; fin_next = fin_reg;
        ov_next = ov_reg; od_next = od_reg; ol_next = ol_reg;
        fr_we = 1'b0; fr_addr = '0; fr_wdata = '0;
        ow_we = 1'b0; ow_addr = '0; ow_wdata = '0;
        ee_we = 1'b0; ee_addr = '0; ee_wdata = '0;
        fv = fr_rdata & mask;
        both = fu_reg & fv;
        other = (c_reg == ca_reg) ? cb_reg : ca_reg;
        out_free = !ov_reg || m_tready;
        if (ov_reg && m_tready) ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !ov_reg)
                begin
                    e_next = s_tdata[7:0];
                    u_next = s_tdata[13:8];
                    v_next = s_tdata[19:14];
                    if (s_tuser == CMD_CLEAR)
                    begin
                        clr_next = '0;
                        ov_next = 1'b1; od_next = '0; ol_next = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else if (s_tdata[7:0] == '0 || 32'(s_tdata[7:0]) > MAX_EDGES ||
                             s_tdata[13:8] == '0 || 32'(s_tdata[13:8]) > MAX_VERTICES ||
                             s_tdata[19:14] == '0 || 32'(s_tdata[19:14]) > MAX_VERTICES)
                    begin
                        ov_next = 1'b1; od_next = {3'b001, 5'd0, s_tdata[7:0]};
                        ol_next = 1'b1;
                    end
                    else
                        state_next = ST_RD_FREE;
                end
            end
            // sweep owner memory; free memory rides along on the low rows
            ST_CLEAR:
            begin
                ow_we = 1'b1; ow_addr = clr_reg; ow_wdata = '0;
                if (32'(clr_reg) <= MAX_VERTICES)
                begin
                    fr_we = 1'b1; fr_addr = VA'(clr_reg); fr_wdata = '1;
                end
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == ODEPTH - 1) state_next = ST_IDLE;
            end
            ST_RD_FREE:
            begin
                fr_addr = VA'(u_reg); state_next = ST_WAIT_FREE;
            end
            ST_WAIT_FREE:
            begin
                fr_addr = VA'(v_reg);
                fu_next = fr_rdata & mask;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (fu_reg == '0 || fv == '0)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; od_next = {3'b001, 5'd0, e_reg};
                        ol_next = 1'b1; state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ee_we = 1'b1; ee_addr = EA'(e_reg); ee_wdata = {v_reg, u_reg};
                    f_next = e_reg; f0_next = u_reg; f1_next = v_reg;
                    k_next = '0;
                    if (both != '0)
                    begin
                        c_next = lowest(both); ca_next = lowest(both);
                        cb_next = lowest(both); fin_next = 1'b1;
                        state_next = ST_OWN_U;
                    end
                    else
                    begin
                        ca_next = lowest(fu_reg); cb_next = lowest(fv);
                        c_next = lowest(fu_reg); w_next = v_reg; fin_next = 1'b0;
                        state_next = ST_RD_OWNER;
                    end
                end
            end
            // direct: two owner writes then free updates
            ST_OWN_U:
            begin
                ow_we = 1'b1; ow_addr = oidx(u_reg, c_reg); ow_wdata = e_reg;
                state_next = ST_OWN_V;
            end
            ST_OWN_V:
            begin
                ow_we = 1'b1; ow_addr = oidx(v_reg, c_reg); ow_wdata = e_reg;
                fr_addr = VA'(u_reg);
                state_next = ST_FREE_U;
            end
            ST_FREE_U:
            begin
                fr_we = 1'b1; fr_addr = VA'(u_reg);
                fr_wdata = fr_rdata & ~(MAX_COLORS'(1) << (c_reg - 1'b1));
                state_next = ST_FREE_V;
            end
            ST_FREE_V:
            begin
                fr_addr = VA'(v_reg);
                state_next = ST_FIN_V;
            end
            // path walk
            ST_RD_OWNER:
            begin
                ow_addr = oidx(w_reg, c_reg); state_next = ST_WAIT_OWNER;
            end
            ST_WAIT_OWNER:
            begin
                nx_next = ow_rdata; state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (nx_reg == '0 || 32'(k_reg) >= MAX_HOPS)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1; od_next = {3'b000, c_reg, f_reg}; ol_next = 1'b1;
                        k_next = k_reg + 1'b1;
                        state_next = ST_OWN_F0;
                    end
                end
                else if (out_free)
                begin
                    ov_next = 1'b1; od_next = {3'b000, c_reg, f_reg}; ol_next = 1'b0;
                    k_next = k_reg + 1'b1;
                    state_next = ST_RD_ENDS;
                end
            end
            ST_RD_ENDS:
            begin
                ee_addr = EA'(nx_reg); state_next = ST_WAIT_ENDS;
            end
            ST_WAIT_ENDS:
            begin
                // ends of next edge now on ee_rdata; own f first
                ow_we = 1'b1; ow_addr = oidx(f0_reg, c_reg); ow_wdata = f_reg;
                ee_addr = EA'(nx_reg);
                state_next = ST_OWN_F1;
            end
            ST_OWN_F1:
            begin
                ow_we = 1'b1; ow_addr = oidx(f1_reg, c_reg); ow_wdata = f_reg;
                ee_addr = EA'(nx_reg);
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                ee_addr = EA'(nx_reg);
                w_next = (ee_rdata[VERT_W-1:0] == w_reg) ? ee_rdata[2*VERT_W-1:VERT_W]
                                                         : ee_rdata[VERT_W-1:0];
                f0_next = ee_rdata[VERT_W-1:0];
                f1_next = ee_rdata[2*VERT_W-1:VERT_W];
                f_next = nx_reg; c_next = other;
                state_next = ST_RD_OWNER;
            end
            // final edge of the path
            ST_OWN_F0:
            begin
                ow_we = 1'b1; ow_addr = oidx(f0_reg, c_reg); ow_wdata = f_reg;
                state_next = ST_FIN_OWN;
            end
            ST_FIN_OWN:
            begin
                ow_we = 1'b1; ow_addr = oidx(f1_reg, c_reg); ow_wdata = f_reg;
                fr_addr = VA'(u_reg);
                state_next = ST_FIN_U;
            end
            ST_FIN_U:
            begin
                fr_we = 1'b1; fr_addr = VA'(u_reg);
                fr_wdata = fr_rdata & ~(MAX_COLORS'(1) << (ca_reg - 1'b1));
                state_next = ST_FREE_V;
            end
            ST_FIN_V:
            begin
                fr_we = 1'b1; fr_addr = VA'(v_reg);
                fr_wdata = fr_rdata & ~(MAX_COLORS'(1) << (cb_reg - 1'b1));
                if (fin_reg) state_next = ST_EMIT;
                else
                begin
                    state_next = ST_FIN_W;
                end
            end
            ST_FIN_W:
            begin
                fr_addr = VA'(w_reg); state_next = ST_FIN_WSET;
            end
            ST_FIN_WSET:
            begin
                fr_we = 1'b1; fr_addr = VA'(w_reg);
                fr_wdata = (fr_rdata & ~(MAX_COLORS'(1) << (c_reg - 1'b1)))
                         | (MAX_COLORS'(1) << (other - 1'b1));
                ow_we = 1'b1; ow_addr = oidx(w_reg, other); ow_wdata = '0;
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; od_next = {3'b000, c_reg, e_reg}; ol_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

### rtl/bec_checker.sv
// Port-level checker for the bipartite edge colourer, bound to the top level.
// Depends on nothing beyond the top-level ports.
module bec_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // an error result carries no colour and ends the transaction
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[12:8] == 5'd0 && m_tlast)
        else $error("bad error result");

    // no input accepted while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken with result pending");

    // a clear is acknowledged next cycle
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> m_tvalid && m_tlast && m_tdata == 16'd0)
        else $error("clear not acknowledged");
endmodule

bind bipartite_edge_coloring bec_port_checker u_bec_port_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast));
